### rtl/sorted_key_set_table_macros.svh
// assertion macros used by the sorted key set table
`ifndef SORTED_KEY_SET_TABLE_MACROS_SVH
`define SORTED_KEY_SET_TABLE_MACROS_SVH

`ifndef SYNTH

// plain property checked on every clock edge out of reset
`define SKST_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define SKST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define SKST_ASSERT(label, clk, rst_n, prop, msg)
`define SKST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/skst_pkg.sv
// shared constants, types and codes of the sorted key set table
package skst_pkg;

    // table size and field widths
    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int RANK_W   = 7;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [CMD_W-1:0]        t_cmd;
    typedef logic [STATUS_W-1:0]     t_status;
    typedef logic [RANK_W-1:0]       t_rank;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic signed [KEY_W-1:0] t_key;

    // command codes
    localparam t_cmd CMD_INSERT    = 3'd0;
    localparam t_cmd CMD_DELETE    = 3'd1;
    localparam t_cmd CMD_SEARCH    = 3'd2;
    localparam t_cmd CMD_LIST_ASC  = 3'd3;
    localparam t_cmd CMD_LIST_DESC = 3'd4;

    // status codes
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_DUP      = 3'd1;
    localparam t_status ST_NOTFOUND = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // result of the shared key comparator
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DECIDE,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_WR,
        S_EMIT,
        S_LIST_OUT
    } t_state;

endpackage

### rtl/skst_in_if.sv
// command channel: valid/ready handshake with command and key
interface skst_in_if;
    logic                valid;
    logic                ready;
    skst_pkg::t_cmd      cmd;
    skst_pkg::t_key      key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

### rtl/skst_out_if.sv
// result channel: valid/ready handshake with status, key, rank and last flag
interface skst_out_if;
    logic                valid;
    logic                ready;
    skst_pkg::t_status   status;
    skst_pkg::t_key      key_out;
    skst_pkg::t_rank     rank;
    logic                last;

    modport source (output valid, output status, output key_out, output rank, output last,
                    input ready);
    modport sink   (input valid, input status, input key_out, input rank, input last,
                    output ready);
endinterface

### rtl/skst_ram.sv
// generic simple dual-port ram with registered read
module skst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/skst_cmp.sv
// shared signed key comparator
module skst_cmp (
    input  skst_pkg::t_key     i_a,
    input  skst_pkg::t_key     i_b,
    output skst_pkg::t_cmp_res o_res
);

    // stored key against command key
    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

### rtl/sorted_key_set_table.sv
// sorted key set table: sequencer, key store and shared comparator
//
// Keeps up to CAPACITY distinct signed 32-bit keys in ascending order in one
// single-port-read ram and serves one command at a time; the command port is
// ready only while the table is idle. Timing is set by the single ram read
// port and the one comparator: the ordered scan looks at one stored key per
// cycle, and an insert or delete moves the keys it shifts one at a time. A
// list command emits one result per cycle while the result side does not
// stall. The first key is fetched in the idle state, while the command is
// taken. Commands with codes above list descending are taken and dropped
// with no result. The key store needs no clearing after reset; only keys
// read from slots below the key count are ever used. A finished result
// waits in an output register and the next command is taken while it waits.
`include "sorted_key_set_table_macros.svh"

module sorted_key_set_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    skst_in_if.sink           i_in,
    skst_out_if.source        o_out
);

    // sequencer and command registers
    skst_pkg::t_state   r_state, n_state;
    skst_pkg::t_cmd     r_cmd, n_cmd;
    skst_pkg::t_key     r_key, n_key;
    skst_pkg::t_cnt     r_idx, n_idx;
    skst_pkg::t_cnt     r_pos, n_pos;
    logic               r_found, n_found;
    skst_pkg::t_cnt     r_count, n_count;
    skst_pkg::t_status  r_res_status, n_res_status;
    skst_pkg::t_key     r_res_key, n_res_key;

    // output register
    logic               r_o_valid, n_o_valid;
    skst_pkg::t_status  r_o_status, n_o_status;
    skst_pkg::t_key     r_o_key, n_o_key;
    skst_pkg::t_rank    r_o_rank, n_o_rank;
    logic               r_o_last, n_o_last;

    // ram port and comparator signals
    logic                w_we;
    skst_pkg::t_addr     w_waddr;
    skst_pkg::t_key      w_wdata;
    skst_pkg::t_addr     w_raddr;
    skst_pkg::t_key      w_rdata;
    skst_pkg::t_cmp_res  w_cmp;

    // shared index arithmetic
    skst_pkg::t_cnt      w_idx_inc, w_idx_inc2, w_idx_dec, w_idx_dec2, w_cnt_dec, w_pos_inc;
    logic                w_slot_free;
    logic                w_full;
    logic                w_list_final;
    logic                w_is_asc;

    assign w_idx_inc    = r_idx + skst_pkg::t_cnt'(1);
    assign w_idx_inc2   = r_idx + skst_pkg::t_cnt'(2);
    assign w_idx_dec    = r_idx - skst_pkg::t_cnt'(1);
    assign w_idx_dec2   = r_idx - skst_pkg::t_cnt'(2);
    assign w_cnt_dec    = r_count - skst_pkg::t_cnt'(1);
    assign w_pos_inc    = r_pos + skst_pkg::t_cnt'(1);
    assign w_slot_free  = !r_o_valid || o_out.ready;
    assign w_full       = (r_count == skst_pkg::t_cnt'(skst_pkg::CAPACITY));
    assign w_is_asc     = (r_cmd == skst_pkg::CMD_LIST_ASC);
    assign w_list_final = w_is_asc ? (w_idx_inc == r_count) : (r_idx == '0);

    // key store
    skst_ram #(
        .WIDTH (skst_pkg::KEY_W),
        .DEPTH (skst_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // comparator shared by the scan
    skst_cmp u_cmp (
        .i_a   (w_rdata),
        .i_b   (r_key),
        .o_res (w_cmp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skst_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.cmd == skst_pkg::CMD_INSERT) begin
                        n_state = (r_count == '0) ? skst_pkg::S_DECIDE : skst_pkg::S_CMP;
                    end else if (i_in.cmd > skst_pkg::CMD_LIST_DESC) begin
                        n_state = skst_pkg::S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = skst_pkg::S_EMIT;
                    end else if (i_in.cmd inside {skst_pkg::CMD_LIST_ASC,
                                                  skst_pkg::CMD_LIST_DESC}) begin
                        n_state = skst_pkg::S_LIST_OUT;
                    end else begin
                        n_state = skst_pkg::S_CMP;
                    end
                end
            end
            skst_pkg::S_CMP: begin
                if (!w_cmp.lt || w_idx_inc == r_count) begin
                    n_state = skst_pkg::S_DECIDE;
                end
            end
            skst_pkg::S_DECIDE: begin
                if (r_cmd == skst_pkg::CMD_INSERT) begin
                    if (r_found || w_full) begin
                        n_state = skst_pkg::S_EMIT;
                    end else if (r_pos == r_count) begin
                        n_state = skst_pkg::S_INS_PUT;
                    end else begin
                        n_state = skst_pkg::S_INS_WR;
                    end
                end else if (!r_found || r_cmd == skst_pkg::CMD_SEARCH
                             || w_pos_inc == r_count) begin
                    n_state = skst_pkg::S_EMIT;
                end else begin
                    n_state = skst_pkg::S_DEL_WR;
                end
            end
            skst_pkg::S_INS_WR: begin
                if (w_idx_dec == r_pos) begin
                    n_state = skst_pkg::S_INS_PUT;
                end
            end
            skst_pkg::S_INS_PUT: begin
                n_state = skst_pkg::S_EMIT;
            end
            skst_pkg::S_DEL_WR: begin
                if (w_idx_inc2 == r_count) begin
                    n_state = skst_pkg::S_EMIT;
                end
            end
            skst_pkg::S_EMIT: begin
                if (w_slot_free) begin
                    n_state = skst_pkg::S_IDLE;
                end
            end
            skst_pkg::S_LIST_OUT: begin
                if (w_slot_free && w_list_final) begin
                    n_state = skst_pkg::S_IDLE;
                end
            end
            default: n_state = skst_pkg::S_IDLE;
        endcase
    end

    // datapath, ram control and result register loads
    always_comb begin
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_found      = r_found;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_key    = r_res_key;
        n_o_valid    = r_o_valid && !o_out.ready;
        n_o_status   = r_o_status;
        n_o_key      = r_o_key;
        n_o_rank     = r_o_rank;
        n_o_last     = r_o_last;
        w_we         = 1'b0;
        w_waddr      = r_idx[skst_pkg::ADDR_W-1:0];
        w_wdata      = w_rdata;
        w_raddr      = r_idx[skst_pkg::ADDR_W-1:0];

        unique case (r_state)
            skst_pkg::S_IDLE: begin
                // prefetch the first key the command will look at
                w_raddr = (i_in.cmd == skst_pkg::CMD_LIST_DESC)
                          ? w_cnt_dec[skst_pkg::ADDR_W-1:0] : '0;
                if (i_in.valid) begin
                    n_cmd        = i_in.cmd;
                    n_key        = i_in.key;
                    n_idx        = (i_in.cmd == skst_pkg::CMD_LIST_DESC) ? w_cnt_dec : '0;
                    n_pos        = '0;
                    n_found      = 1'b0;
                    n_res_status = skst_pkg::ST_EMPTY;
                    n_res_key    = '0;
                end
            end
            skst_pkg::S_CMP: begin
                // ordered scan: one stored key per cycle
                w_raddr = w_idx_inc[skst_pkg::ADDR_W-1:0];
                if (w_cmp.lt && w_idx_inc != r_count) begin
                    n_idx = w_idx_inc;
                end else begin
                    n_pos   = w_cmp.lt ? r_count : r_idx;
                    n_found = !w_cmp.lt && w_cmp.eq;
                end
            end
            skst_pkg::S_DECIDE: begin
                if (r_cmd == skst_pkg::CMD_INSERT) begin
                    if (r_found) begin
                        n_res_status = skst_pkg::ST_DUP;
                        n_res_key    = '0;
                    end else if (w_full) begin
                        n_res_status = skst_pkg::ST_FULL;
                        n_res_key    = '0;
                    end else begin
                        n_res_status = skst_pkg::ST_OK;
                        n_res_key    = r_key;
                        n_idx        = r_count;
                        w_raddr      = w_cnt_dec[skst_pkg::ADDR_W-1:0];
                    end
                end else if (!r_found) begin
                    n_res_status = skst_pkg::ST_NOTFOUND;
                    n_res_key    = '0;
                end else begin
                    n_res_status = skst_pkg::ST_OK;
                    n_res_key    = r_key;
                    if (r_cmd == skst_pkg::CMD_DELETE) begin
                        if (w_pos_inc == r_count) begin
                            n_count = w_cnt_dec;
                        end else begin
                            n_idx   = r_pos;
                            w_raddr = w_pos_inc[skst_pkg::ADDR_W-1:0];
                        end
                    end
                end
            end
            skst_pkg::S_INS_WR: begin
                // move one key up and fetch the one below it
                w_we    = 1'b1;
                w_waddr = r_idx[skst_pkg::ADDR_W-1:0];
                w_wdata = w_rdata;
                w_raddr = w_idx_dec2[skst_pkg::ADDR_W-1:0];
                n_idx   = w_idx_dec;
            end
            skst_pkg::S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[skst_pkg::ADDR_W-1:0];
                w_wdata = r_key;
                n_count = r_count + skst_pkg::t_cnt'(1);
            end
            skst_pkg::S_DEL_WR: begin
                // move one key down and fetch the one above it
                w_we    = 1'b1;
                w_waddr = r_idx[skst_pkg::ADDR_W-1:0];
                w_wdata = w_rdata;
                w_raddr = w_idx_inc2[skst_pkg::ADDR_W-1:0];
                n_idx   = w_idx_inc;
                if (w_idx_inc2 == r_count) begin
                    n_count = w_cnt_dec;
                end
            end
            skst_pkg::S_EMIT: begin
                if (w_slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_key    = r_res_key;
                    n_o_rank   = '0;
                    n_o_last   = 1'b1;
                end
            end
            skst_pkg::S_LIST_OUT: begin
                // one listed key per cycle, ram address held while stalled
                if (w_slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = skst_pkg::ST_OK;
                    n_o_key    = w_rdata;
                    n_o_rank   = skst_pkg::t_rank'(w_idx_inc);
                    n_o_last   = w_list_final;
                    if (!w_list_final) begin
                        n_idx   = w_is_asc ? w_idx_inc : w_idx_dec;
                        w_raddr = w_is_asc ? w_idx_inc[skst_pkg::ADDR_W-1:0]
                                           : w_idx_dec[skst_pkg::ADDR_W-1:0];
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= skst_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_found      <= n_found;
        r_res_status <= n_res_status;
        r_res_key    <= n_res_key;
        r_o_status   <= n_o_status;
        r_o_key      <= n_o_key;
        r_o_rank     <= n_o_rank;
        r_o_last     <= n_o_last;
    end

    // ports
    assign i_in.ready    = (r_state == skst_pkg::S_IDLE);
    assign o_out.valid   = r_o_valid;
    assign o_out.status  = r_o_status;
    assign o_out.key_out = r_o_key;
    assign o_out.rank    = r_o_rank;
    assign o_out.last    = r_o_last;

    // checks
    `SKST_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= skst_pkg::t_cnt'(skst_pkg::CAPACITY), "key count above capacity")
    `SKST_ASSERT_IMPL(a_count_step, i_clk, i_rst_n, $past(i_rst_n) && r_count != $past(r_count), $past(r_state) == skst_pkg::S_INS_PUT || $past(r_state) == skst_pkg::S_DECIDE || $past(r_state) == skst_pkg::S_DEL_WR, "key count changed outside insert or delete")
    `SKST_ASSERT_IMPL(a_mid_list, i_clk, i_rst_n, r_o_valid && !r_o_last, r_o_status == skst_pkg::ST_OK && r_o_rank != '0, "non-final result is not a listed key")
    `SKST_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_o_valid && r_o_status != skst_pkg::ST_OK, r_o_key == '0 && r_o_rank == '0, "error result carries key or rank")

endmodule

### bench/sorted_key_set_table_tb.sv
// testbench for the sorted key set table: random bursts, result stalls, scoreboard
`timescale 1ns / 1ps

module sorted_key_set_table_tb;

    // run limits
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  RANDOM_ITEMS = 470;
    localparam int  POOL_SIZE    = 40;
    localparam int  PRINT_LIMIT  = 50;

    // codes the block takes and drops
    localparam skst_pkg::t_cmd CMD_RSVD5 = 3'd5;
    localparam skst_pkg::t_cmd CMD_RSVD6 = 3'd6;
    localparam skst_pkg::t_cmd CMD_RSVD7 = 3'd7;

    // key extremes
    localparam skst_pkg::t_key KEY_MIN = skst_pkg::t_key'(32'h8000_0000);
    localparam skst_pkg::t_key KEY_MAX = skst_pkg::t_key'(32'h7fff_ffff);

    typedef struct {
        skst_pkg::t_cmd cmd;
        skst_pkg::t_key key;
    } t_cmd_item;

    typedef struct {
        skst_pkg::t_status status;
        skst_pkg::t_key    key_out;
        skst_pkg::t_rank   rank;
        logic              last;
    } t_result_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    skst_in_if  cmd_if ();
    skst_out_if res_if ();

    sorted_key_set_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // command items waiting to be sent, results waiting to arrive
    t_cmd_item    pending_cmds[$];
    t_result_item expected_results[$];

    // predicted table contents, ascending
    skst_pkg::t_key table_keys[$];

    skst_pkg::t_key key_pool[POOL_SIZE];
    skst_pkg::t_key recent_key;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("check failed at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void push_result(skst_pkg::t_status st, skst_pkg::t_key k,
                                        skst_pkg::t_rank r, logic lst);
        t_result_item res;
        res.status  = st;
        res.key_out = k;
        res.rank    = r;
        res.last    = lst;
        expected_results.push_back(res);
    endfunction

    // work out the results of one accepted command and update the table copy
    function automatic void predict_table_results(skst_pkg::t_cmd cmd, skst_pkg::t_key k);
        int pos;
        int n;
        bit hit;
        n   = table_keys.size();
        pos = 0;
        while (pos < n && table_keys[pos] < k)
            pos++;
        hit = (pos < n) && (table_keys[pos] == k);
        case (cmd)
            skst_pkg::CMD_INSERT: begin
                if (hit)
                    push_result(skst_pkg::ST_DUP, '0, '0, 1'b1);
                else if (n >= skst_pkg::CAPACITY)
                    push_result(skst_pkg::ST_FULL, '0, '0, 1'b1);
                else begin
                    table_keys.insert(pos, k);
                    push_result(skst_pkg::ST_OK, k, '0, 1'b1);
                end
            end
            skst_pkg::CMD_DELETE, skst_pkg::CMD_SEARCH: begin
                if (n == 0)
                    push_result(skst_pkg::ST_EMPTY, '0, '0, 1'b1);
                else if (!hit)
                    push_result(skst_pkg::ST_NOTFOUND, '0, '0, 1'b1);
                else begin
                    if (cmd == skst_pkg::CMD_DELETE)
                        table_keys.delete(pos);
                    push_result(skst_pkg::ST_OK, k, '0, 1'b1);
                end
            end
            skst_pkg::CMD_LIST_ASC: begin
                if (n == 0)
                    push_result(skst_pkg::ST_EMPTY, '0, '0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_result(skst_pkg::ST_OK, table_keys[i],
                                skst_pkg::t_rank'(i + 1), i == n - 1);
            end
            skst_pkg::CMD_LIST_DESC: begin
                if (n == 0)
                    push_result(skst_pkg::ST_EMPTY, '0, '0, 1'b1);
                for (int i = n - 1; i >= 0; i--)
                    push_result(skst_pkg::ST_OK, table_keys[i],
                                skst_pkg::t_rank'(i + 1), i == 0);
            end
            default: ;
        endcase
    endfunction

    function automatic void add_cmd(skst_pkg::t_cmd c, skst_pkg::t_key k);
        t_cmd_item it;
        it.cmd = c;
        it.key = k;
        pending_cmds.push_back(it);
    endfunction

    // one random command; keys mostly from the pool so hits and duplicates are common
    function automatic t_cmd_item random_command(int insert_pct);
        t_cmd_item it;
        int pick;
        int src;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct)
            it.cmd = skst_pkg::CMD_INSERT;
        else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                it.cmd = skst_pkg::CMD_DELETE;
            else if (pick < 65)
                it.cmd = skst_pkg::CMD_SEARCH;
            else if (pick < 80)
                it.cmd = skst_pkg::CMD_LIST_ASC;
            else if (pick < 95)
                it.cmd = skst_pkg::CMD_LIST_DESC;
            else begin
                case ($urandom_range(0, 2))
                    0:       it.cmd = CMD_RSVD5;
                    1:       it.cmd = CMD_RSVD6;
                    default: it.cmd = CMD_RSVD7;
                endcase
            end
        end
        src = $urandom_range(0, 9);
        if (src < 8)
            it.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (src == 8)
            it.key = recent_key;
        else begin
            it.key     = skst_pkg::t_key'($urandom);
            recent_key = it.key;
        end
        return it;
    endfunction

    // stimulus build, reset and end of run
    initial begin
        int             random_count;
        int             phase_len;
        int             insert_pct;
        int             j;
        bit             dup;
        skst_pkg::t_key k;
        t_cmd_item      it;

        cmd_if.valid = 1'b0;
        cmd_if.cmd   = skst_pkg::CMD_INSERT;
        cmd_if.key   = '0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;

        // distinct key pool with both extremes, zero and minus one
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++) begin
            do begin
                if ($urandom_range(0, 1) == 0)
                    k = skst_pkg::t_key'($urandom_range(0, 200)) - 100;
                else
                    k = skst_pkg::t_key'($urandom);
                dup = 1'b0;
                for (j = 0; j < i; j++)
                    if (key_pool[j] == k)
                        dup = 1'b1;
            end while (dup);
            key_pool[i] = k;
        end
        recent_key = key_pool[4];

        // empty table cases and dropped codes
        add_cmd(skst_pkg::CMD_LIST_ASC, '0);
        add_cmd(skst_pkg::CMD_LIST_DESC, '0);
        add_cmd(skst_pkg::CMD_DELETE, 5);
        add_cmd(skst_pkg::CMD_SEARCH, 5);
        add_cmd(CMD_RSVD5, KEY_MAX);
        add_cmd(CMD_RSVD6, KEY_MIN);
        add_cmd(CMD_RSVD7, -1);
        // inserts at the extremes and in the middle, with a duplicate
        add_cmd(skst_pkg::CMD_INSERT, '0);
        add_cmd(skst_pkg::CMD_INSERT, KEY_MIN);
        add_cmd(skst_pkg::CMD_INSERT, KEY_MAX);
        add_cmd(skst_pkg::CMD_INSERT, -1);
        add_cmd(skst_pkg::CMD_INSERT, '0);
        add_cmd(skst_pkg::CMD_INSERT, 1);
        add_cmd(skst_pkg::CMD_SEARCH, KEY_MIN);
        add_cmd(skst_pkg::CMD_SEARCH, 2);
        add_cmd(skst_pkg::CMD_SEARCH, KEY_MAX);
        add_cmd(skst_pkg::CMD_LIST_ASC, '0);
        add_cmd(skst_pkg::CMD_LIST_DESC, KEY_MAX);
        // deletes: absent, middle, first, last, then down to empty
        add_cmd(skst_pkg::CMD_DELETE, 7);
        add_cmd(skst_pkg::CMD_DELETE, '0);
        add_cmd(skst_pkg::CMD_DELETE, KEY_MIN);
        add_cmd(skst_pkg::CMD_DELETE, KEY_MAX);
        add_cmd(skst_pkg::CMD_LIST_ASC, '0);
        add_cmd(skst_pkg::CMD_DELETE, -1);
        add_cmd(skst_pkg::CMD_DELETE, 1);
        add_cmd(skst_pkg::CMD_LIST_DESC, '0);

        // fill from the whole pool in random order: reaches full, then refusals
        key_pool.shuffle();
        foreach (key_pool[i])
            add_cmd(skst_pkg::CMD_INSERT, key_pool[i]);
        add_cmd(skst_pkg::CMD_LIST_ASC, '0);
        add_cmd(skst_pkg::CMD_LIST_DESC, '0);
        random_count = POOL_SIZE + 2;

        // alternating drain and grow phases
        insert_pct = 20;
        while (random_count < RANDOM_ITEMS) begin
            phase_len = $urandom_range(40, 80);
            for (int i = 0; i < phase_len; i++) begin
                it = random_command(insert_pct);
                pending_cmds.push_back(it);
                if (it.cmd <= skst_pkg::CMD_LIST_DESC)
                    random_count++;
            end
            insert_pct = (insert_pct == 20) ? 75 : 20;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every command to go in and every result to come back
        while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_results.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // command driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_cmd_item it;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (cmd_if.valid && !cmd_if.ready) begin
            // hold the current item until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
            it = pending_cmds.pop_front();
            cmd_if.valid <= 1'b1;
            cmd_if.cmd   <= it.cmd;
            cmd_if.key   <= it.key;
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
        end else begin
            cmd_if.valid <= 1'b0;
        end
    end

    // result stall pattern: a rotating mask replaced every so often
    logic [15:0] stall_mask = 16'hffff;
    int          mask_pos   = 0;
    int          mask_left  = 0;

    always @(posedge i_clk) begin
        if (mask_left == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_mask = 16'hffff;
                1:       stall_mask = 16'($urandom & $urandom) | 16'h0001;
                default: stall_mask = 16'($urandom) | 16'h0001;
            endcase
            mask_left = $urandom_range(50, 300);
        end
        mask_left--;
        res_if.ready <= stall_mask[mask_pos];
        mask_pos = (mask_pos + 1) % 16;
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge i_clk) begin
        t_result_item want;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                predict_table_results(cmd_if.cmd, cmd_if.key);
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d key %0d",
                                              res_if.status, res_if.key_out));
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  res_if.status, want.status));
                    if (res_if.key_out !== want.key_out)
                        report_mismatch($sformatf("key_out %0d, predicted %0d",
                                                  res_if.key_out, want.key_out));
                    if (res_if.rank !== want.rank)
                        report_mismatch($sformatf("rank %0d, predicted %0d",
                                                  res_if.rank, want.rank));
                    if (res_if.last !== want.last)
                        report_mismatch($sformatf("last %0b, predicted %0b",
                                                  res_if.last, want.last));
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
